>>> sv/skit_pkg.sv
// shared types and constants for the sorted key index table
`timescale 1ns / 1ps

package skit_pkg;

    localparam int CAPACITY  = 64;
    localparam int KEY_BYTES = 8;
    localparam int KEY_W     = 8 * KEY_BYTES;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int ADDR_W    = 32;
    localparam int MAXE_W    = 7;
    localparam int ENTRY_W   = 7;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_SEARCH = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_DUPLICATE = 2'd3
    } status_t;

    typedef enum logic {
        REG_UNIQUE_MODE = 1'b0,
        REG_MAX_ENTRIES = 1'b1
    } reg_idx_t;

    // broadcast to every cell of the chain
    typedef struct packed {
        logic              insert;
        logic              remove;
        logic [KEY_W-1:0]  key;
        logic [ADDR_W-1:0] addr;
    } cell_op_t;

    // per-cell compare results
    typedef struct packed {
        logic hit;
        logic not_less;
    } cell_flags_t;

endpackage

>>> sv/skit_cell.sv
// one table slot: key and address register with its own comparator
`timescale 1ns / 1ps

module skit_cell (
    input  logic                          clk,
    input  skit_pkg::cell_op_t            op,
    input  logic                          valid,
    input  logic                          left_not_less,
    input  logic [skit_pkg::KEY_W-1:0]    left_key,
    input  logic [skit_pkg::ADDR_W-1:0]   left_addr,
    input  logic [skit_pkg::KEY_W-1:0]    right_key,
    input  logic [skit_pkg::ADDR_W-1:0]   right_addr,
    output skit_pkg::cell_flags_t         flags,
    output logic [skit_pkg::KEY_W-1:0]    key_q,
    output logic [skit_pkg::ADDR_W-1:0]   addr_q
);

    logic [skit_pkg::KEY_W-1:0]  key_reg;
    logic [skit_pkg::KEY_W-1:0]  key_next;
    logic [skit_pkg::ADDR_W-1:0] addr_reg;
    logic [skit_pkg::ADDR_W-1:0] addr_next;

    // empty slots count as not smaller so an insert lands at the tail
    always_comb
    begin
        flags.not_less = !valid || (key_reg >= op.key);
        flags.hit      = valid && (key_reg == op.key);
    end

    always_comb
    begin
        key_next  = key_reg;
        addr_next = addr_reg;
        if (op.insert)
        begin
            if (left_not_less)
            begin
                key_next  = left_key;
                addr_next = left_addr;
            end
            else if (flags.not_less)
            begin
                key_next  = op.key;
                addr_next = op.addr;
            end
        end
        else if (op.remove && flags.not_less)
        begin
            key_next  = right_key;
            addr_next = right_addr;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        addr_reg <= addr_next;
    end

    assign key_q  = key_reg;
    assign addr_q = addr_reg;

endmodule

>>> sv/sorted_key_index_table_unit.sv
// top level: command intake, chain of table cells, result register, apb registers
`timescale 1ns / 1ps

// sorted key index table
// keeps up to CAPACITY (key, record address) pairs in ascending key order in a
// chain of cells, each cell holding one pair and comparing it against the key
// of the current command; an insert shifts the pairs not below the key one
// cell up, a remove shifts the pairs above the first match one cell down.
// input channel: command, key, record_address with in_valid / in_ready.
// output channel: status, found_address, entry_count with out_valid / out_ready.
// a transfer on the input lands in a command register; once the output
// register is free all cells compare in parallel and update, and the result
// enters the output register, which raises out_valid.
// throughput is one item per cycle while the receiver takes results; the
// cell compare plus the first-match address select sets the cycle.
// when the receiver stalls the result is held, the waiting command stays in
// its register and in_ready drops until the output register frees up.
// reset clears the entry count, the handshakes and the registers
// (unique_mode 0, max_entries 64); cell contents are not cleared and are
// never read above the entry count.
// apb: byte address 0 unique_mode, byte address 4 max_entries; write only idle.

module sorted_key_index_table_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    // command channel
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [1:0]                     command,
    input  logic [63:0]                    key,
    input  logic [skit_pkg::ADDR_W-1:0]    record_address,
    // result channel
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [1:0]                     status,
    output logic [skit_pkg::ADDR_W-1:0]    found_address,
    output logic [skit_pkg::ENTRY_W-1:0]   entry_count,
    // register port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [2:0]                     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    // configuration registers
    logic                          unique_mode_reg;
    logic [skit_pkg::MAXE_W-1:0]   max_entries_reg;

    // command register
    logic                          pend_reg;
    logic                          pend_next;
    skit_pkg::cmd_t                cmd_q_reg;
    logic [skit_pkg::KEY_W-1:0]    key_q_reg;
    logic [skit_pkg::ADDR_W-1:0]   addr_q_reg;

    // table occupancy
    logic [skit_pkg::CNT_W-1:0]    count_reg;
    logic [skit_pkg::CNT_W-1:0]    count_next;
    logic [skit_pkg::CNT_W-1:0]    limit;

    // result register
    logic                          out_valid_reg;
    logic                          out_valid_next;
    skit_pkg::status_t             status_reg;
    skit_pkg::status_t             status_next;
    logic [skit_pkg::ADDR_W-1:0]   found_reg;
    logic [skit_pkg::ADDR_W-1:0]   found_next;

    // chain wiring
    skit_pkg::cell_op_t            op;
    skit_pkg::cell_flags_t         flags  [skit_pkg::CAPACITY];
    logic [skit_pkg::KEY_W-1:0]    cell_key  [skit_pkg::CAPACITY];
    logic [skit_pkg::ADDR_W-1:0]   cell_addr [skit_pkg::CAPACITY];
    logic [skit_pkg::CAPACITY-1:0] hit_vec;
    logic                          any_hit;
    logic [skit_pkg::ADDR_W-1:0]   hit_addr;

    logic                          fire;
    logic                          do_insert;
    logic                          do_remove;
    logic                          cfg_write;

    // -------------------------------------------------------------------
    // handshakes: a new command may enter in the cycle the old one retires
    // -------------------------------------------------------------------
    assign fire     = pend_reg && (!out_valid_reg || out_ready);
    assign in_ready = !pend_reg || fire;

    always_comb
    begin
        pend_next = pend_reg;
        if (in_valid && in_ready)
        begin
            pend_next = 1'b1;
        end
        else if (fire)
        begin
            pend_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    // command payload, key bits above the key width dropped here
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd_q_reg  <= skit_pkg::cmd_t'(command);
            key_q_reg  <= key[skit_pkg::KEY_W-1:0];
            addr_q_reg <= record_address;
        end
    end

    // -------------------------------------------------------------------
    // chain of cells
    // -------------------------------------------------------------------
    assign op.insert = do_insert;
    assign op.remove = do_remove;
    assign op.key    = key_q_reg;
    assign op.addr   = addr_q_reg;

    for (genvar i = 0; i < skit_pkg::CAPACITY; i++)
    begin : g_cell
        logic                        valid;
        logic                        left_nl;
        logic [skit_pkg::KEY_W-1:0]  left_k;
        logic [skit_pkg::ADDR_W-1:0] left_a;
        logic [skit_pkg::KEY_W-1:0]  right_k;
        logic [skit_pkg::ADDR_W-1:0] right_a;

        assign valid = (skit_pkg::CNT_W'(i) < count_reg);

        if (i == 0)
        begin : g_first
            assign left_nl = 1'b0;
            assign left_k  = key_q_reg;
            assign left_a  = addr_q_reg;
        end
        else
        begin : g_mid
            assign left_nl = flags[i-1].not_less;
            assign left_k  = cell_key[i-1];
            assign left_a  = cell_addr[i-1];
        end

        if (i == skit_pkg::CAPACITY - 1)
        begin : g_last
            assign right_k = cell_key[i];
            assign right_a = cell_addr[i];
        end
        else
        begin : g_inner
            assign right_k = cell_key[i+1];
            assign right_a = cell_addr[i+1];
        end

        skit_cell u_cell (
            .clk           (clk),
            .op            (op),
            .valid         (valid),
            .left_not_less (left_nl),
            .left_key      (left_k),
            .left_addr     (left_a),
            .right_key     (right_k),
            .right_addr    (right_a),
            .flags         (flags[i]),
            .key_q         (cell_key[i]),
            .addr_q        (cell_addr[i])
        );

        assign hit_vec[i] = flags[i].hit;
    end

    assign any_hit = |hit_vec;

    // equal keys sit next to each other, so the first hit has no hit below it
    always_comb
    begin
        hit_addr = '0;
        for (int i = 0; i < skit_pkg::CAPACITY; i++)
        begin
            if (hit_vec[i] && ((i == 0) || !hit_vec[(i == 0) ? 0 : i - 1]))
            begin
                hit_addr = hit_addr | cell_addr[i];
            end
        end
    end

    // -------------------------------------------------------------------
    // command decode
    // -------------------------------------------------------------------
    // a limit above capacity acts as capacity
    always_comb
    begin
        if (32'(max_entries_reg) > 32'(skit_pkg::CAPACITY))
        begin
            limit = skit_pkg::CNT_W'(skit_pkg::CAPACITY);
        end
        else
        begin
            limit = skit_pkg::CNT_W'(max_entries_reg);
        end
    end

    always_comb
    begin
        do_insert   = 1'b0;
        do_remove   = 1'b0;
        status_next = skit_pkg::ST_DONE;
        found_next  = '0;
        unique case (cmd_q_reg)
            skit_pkg::CMD_INSERT:
            begin
                // duplicate wins over full
                if (unique_mode_reg && any_hit)
                begin
                    status_next = skit_pkg::ST_DUPLICATE;
                end
                else if (count_reg >= limit)
                begin
                    status_next = skit_pkg::ST_FULL;
                end
                else
                begin
                    do_insert = fire;
                end
            end
            skit_pkg::CMD_REMOVE:
            begin
                if (any_hit)
                begin
                    do_remove = fire;
                end
                else
                begin
                    status_next = skit_pkg::ST_NOT_FOUND;
                end
            end
            skit_pkg::CMD_SEARCH:
            begin
                if (any_hit)
                begin
                    found_next = hit_addr;
                end
                else
                begin
                    status_next = skit_pkg::ST_NOT_FOUND;
                end
            end
            default:
            begin
                status_next = skit_pkg::ST_DONE;
            end
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (do_insert)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_remove)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // -------------------------------------------------------------------
    // result register
    // -------------------------------------------------------------------
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    logic [skit_pkg::CNT_W-1:0] count_out_reg;

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            status_reg    <= status_next;
            found_reg     <= found_next;
            count_out_reg <= count_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign found_address = found_reg;
    assign entry_count   = skit_pkg::ENTRY_W'(count_out_reg);

    // -------------------------------------------------------------------
    // register port
    // -------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unique_mode_reg <= 1'b0;
            max_entries_reg <= skit_pkg::MAXE_W'(64);
        end
        else if (cfg_write)
        begin
            unique case (skit_pkg::reg_idx_t'(paddr[2]))
                skit_pkg::REG_UNIQUE_MODE: unique_mode_reg <= pwdata[0];
                skit_pkg::REG_MAX_ENTRIES: max_entries_reg <= pwdata[skit_pkg::MAXE_W-1:0];
                default:                   unique_mode_reg <= unique_mode_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (skit_pkg::reg_idx_t'(paddr[2]))
            skit_pkg::REG_UNIQUE_MODE: prdata = {31'b0, unique_mode_reg};
            skit_pkg::REG_MAX_ENTRIES: prdata = {{(32 - skit_pkg::MAXE_W){1'b0}}, max_entries_reg};
            default:                   prdata = '0;
        endcase
    end

    // -------------------------------------------------------------------
    // assertions
    // -------------------------------------------------------------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= 32'(skit_pkg::CAPACITY))
        else $error("entry count above capacity");

    a_stall_holds_table: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> $stable(count_reg))
        else $error("table changed while result stalled");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        do_insert |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("insert did not grow the table");

    a_dup_needs_unique: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (status_next == skit_pkg::ST_DUPLICATE)) |-> unique_mode_reg)
        else $error("duplicate refused outside unique mode");

    a_no_retire_without_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (do_insert || do_remove) |-> pend_reg)
        else $error("table update without a waiting command");

endmodule
